@@ hdl/dual_quadrature_speed_meter_top_assert.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the dual quadrature speed meter
// Concurrent assertion wrappers that drop out of synthesis builds.
// -----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_SPEED_METER_TOP_ASSERT_SVH
`define DUAL_QUADRATURE_SPEED_METER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the cycle after the antecedent.
`define DQSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqsm assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define DQSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqsm assertion failed");

`else

`define DQSM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define DQSM_ASSERT_NOW(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/dqsm_pkg.sv @@
// -----------------------------------------------------------------------------
// Dual quadrature speed meter package
// Shared constants, codes and types for the speed meter modules.
// -----------------------------------------------------------------------------
package dqsm_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int FIELD_W         = 16;
   localparam int BYTE_W          = 8;

   // Request operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Configuration register indexes
   localparam int  CSR_IDX_W          = 1;
   localparam int  CSR_DATA_W         = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR_ONE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR_TWO = 1'd1;

   localparam logic INVERT_DIR_ONE_RST = 1'b0;
   localparam logic INVERT_DIR_TWO_RST = 1'b1;

   localparam logic [1:0] PAIR_MASK = 2'b11;
   localparam logic [1:0] B_BIT     = 2'b01;

   // Control from the top level to one channel tracker
   typedef struct packed {
      logic step_en;
      logic clear;
   } dqsm_trk_ctl_type;

endpackage

@@ hdl/dqsm_channels.sv @@
// -----------------------------------------------------------------------------
// Speed meter channel interfaces
// Valid/ready channels for pin-sample requests and window results.
// -----------------------------------------------------------------------------
interface dqsm_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic enc_one_a;
   logic enc_one_b;
   logic enc_two_a;
   logic enc_two_b;

   modport source (output valid, operation, enc_one_a, enc_one_b, enc_two_a, enc_two_b,
                   input ready);
   modport sink   (input valid, operation, enc_one_a, enc_one_b, enc_two_a, enc_two_b,
                   output ready);
endinterface

interface dqsm_rsp_if import dqsm_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] window_count_one;
   logic signed [FIELD_W-1:0] window_count_two;
   logic signed [FIELD_W-1:0] average_count;
   logic        [BYTE_W-1:0]  average_low_byte;

   modport source (output valid, window_count_one, window_count_two, average_count,
                   average_low_byte, input ready);
   modport sink   (input valid, window_count_one, window_count_two, average_count,
                   average_low_byte, output ready);
endinterface

@@ hdl/dqsm_track.sv @@
// -----------------------------------------------------------------------------
// Quadrature channel tracker
// Holds the last A/B pair and a saturating signed step count for one encoder.
// -----------------------------------------------------------------------------
module dqsm_track import dqsm_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dqsm_trk_ctl_type       ctl,
   input  logic                   pin_a,
   input  logic                   pin_b,
   input  logic                   invert,
   output logic [COUNT_WIDTH-1:0] count
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic [1:0]             prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             now_pair;
   logic [1:0]             diff;
   logic                   moved;
   logic                   dir_down;

   assign now_pair = {pin_a, pin_b};
   assign diff     = (now_pair ^ prev_ff) & PAIR_MASK;
   // Exactly one bit changed: a both-bit jump is not a valid step.
   assign moved    = (diff != 2'b00) && (diff != PAIR_MASK);
   assign dir_down = pin_a ^ |(prev_ff & B_BIT) ^ invert;

   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.step_en) begin
         prev_in = now_pair;
         if (moved) begin
            if (!dir_down && (count_ff != CNT_MAX)) begin
               count_in = count_ff + CNT_ONE;
            end else if (dir_down && (count_ff != CNT_MIN)) begin
               count_in = count_ff - CNT_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

@@ hdl/dual_quadrature_speed_meter_top.sv @@
// -----------------------------------------------------------------------------
// Dual quadrature speed meter
// Decodes two quadrature encoders and reports windowed step counts.
// -----------------------------------------------------------------------------
// Usage:
//   The req_ch channel carries one request per pin sample (operation 0, both
//   A/B pairs) or per window tick (operation 1). A sample produces no result;
//   a tick produces one result on rsp_ch holding both step counts, their
//   average rounded toward zero and the average's low byte, and then clears
//   both counts.
//   Every request first lands in an input register and is applied from
//   there, so a tick's result is written into the result register only
//   once the tick leaves the input register.
//   One request is taken per cycle, set by the single input register stage
//   feeding the counters and the result register, while no tick is stalled.
//   If the receiver stalls, the result register holds its data, a tick
//   waiting in the input register holds, and samples keep flowing only as
//   long as no tick is blocked behind the result.
//   The csr_ port sets the direction inversion of each encoder.
//   Reset (synchronous) clears both counts and stored pairs, empties both
//   registers and restores the inversion defaults: encoder one normal,
//   encoder two inverted.
// -----------------------------------------------------------------------------
`include "dual_quadrature_speed_meter_top_assert.svh"

module dual_quadrature_speed_meter_top import dqsm_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dqsm_req_if.sink              req_ch,
   dqsm_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EXT_W = COUNT_WIDTH + FIELD_W;

   // Configuration
   logic inv_one_ff, inv_one_in;
   logic inv_two_ff, inv_two_in;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [3:0] s1_pins_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_one_ff, rsp_two_ff, rsp_avg_ff;
   logic [BYTE_W-1:0]  rsp_low_ff;

   logic req_take;
   logic out_free;
   logic s1_adv;
   logic tick_adv;

   dqsm_trk_ctl_type       ctl;
   logic [COUNT_WIDTH-1:0] count_one, count_two;
   logic [COUNT_WIDTH:0]   sum, sum_adj;
   logic [COUNT_WIDTH-1:0] avg;
   logic [EXT_W-1:0]       ext_one, ext_two, ext_avg;

   always_comb begin
      inv_one_in = inv_one_ff;
      inv_two_in = inv_two_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INVERT_DIR_ONE: inv_one_in = csr_wdata[0];
            CSR_INVERT_DIR_TWO: inv_two_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A sample always drains; a tick needs room in the result register.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && ((s1_op_ff == OP_SAMPLE) || out_free);
   assign tick_adv     = s1_adv && (s1_op_ff == OP_TICK);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = tick_adv || (rsp_valid_ff && !rsp_ch.ready);

   assign ctl.step_en = s1_adv && (s1_op_ff == OP_SAMPLE);
   assign ctl.clear   = tick_adv;

   dqsm_track #(.COUNT_WIDTH(COUNT_WIDTH)) u_track_one (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .pin_a  (s1_pins_ff[3]),
      .pin_b  (s1_pins_ff[2]),
      .invert (inv_one_ff),
      .count  (count_one)
   );

   dqsm_track #(.COUNT_WIDTH(COUNT_WIDTH)) u_track_two (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .pin_a  (s1_pins_ff[1]),
      .pin_b  (s1_pins_ff[0]),
      .invert (inv_two_ff),
      .count  (count_two)
   );

   // Halving rounds toward zero: add one to a negative sum before the shift.
   assign sum     = {count_one[COUNT_WIDTH-1], count_one}
                  + {count_two[COUNT_WIDTH-1], count_two};
   assign sum_adj = sum + {{COUNT_WIDTH{1'b0}}, sum[COUNT_WIDTH]};
   assign avg     = sum_adj[COUNT_WIDTH:1];

   assign ext_one = {{FIELD_W{count_one[COUNT_WIDTH-1]}}, count_one};
   assign ext_two = {{FIELD_W{count_two[COUNT_WIDTH-1]}}, count_two};
   assign ext_avg = {{FIELD_W{avg[COUNT_WIDTH-1]}}, avg};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_one_ff   <= INVERT_DIR_ONE_RST;
         inv_two_ff   <= INVERT_DIR_TWO_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inv_one_ff   <= inv_one_in;
         inv_two_ff   <= inv_two_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_ch.operation;
         s1_pins_ff <= {req_ch.enc_one_a, req_ch.enc_one_b,
                        req_ch.enc_two_a, req_ch.enc_two_b};
      end
      if (tick_adv) begin
         rsp_one_ff <= ext_one[FIELD_W-1:0];
         rsp_two_ff <= ext_two[FIELD_W-1:0];
         rsp_avg_ff <= ext_avg[FIELD_W-1:0];
         rsp_low_ff <= ext_avg[BYTE_W-1:0];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.window_count_one = rsp_one_ff;
   assign rsp_ch.window_count_two = rsp_two_ff;
   assign rsp_ch.average_count    = rsp_avg_ff;
   assign rsp_ch.average_low_byte = rsp_low_ff;

   `DQSM_ASSERT_NEXT(a_tick_gives_rsp, clock, reset, tick_adv, rsp_valid_ff)
   `DQSM_ASSERT_NEXT(a_tick_clears, clock, reset, tick_adv, (count_one == '0) && (count_two == '0))
   `DQSM_ASSERT_NEXT(a_tick_held, clock, reset, s1_valid_ff && (s1_op_ff == OP_TICK) && !out_free, s1_valid_ff && (s1_op_ff == OP_TICK))
   `DQSM_ASSERT_NOW(a_low_byte, clock, reset, rsp_valid_ff, rsp_low_ff == rsp_avg_ff[BYTE_W-1:0])

endmodule
